### hw/rtl/gb8_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the 8x8 font for the glyph blitter.
// Depends on nothing; every other file of the block refers to it by scoped names.
package gb8_pkg;

    // Field widths
    localparam int COORD_W  = 13;
    localparam int DIM_W    = 13;
    localparam int ADDR_W   = 24;
    localparam int COLOR_W  = 32;
    localparam int CODE_W   = 8;
    localparam int SCR_W    = 12;   // on-screen coordinate, 0 .. MAX_SCREEN_DIM-1

    // Largest screen dimension honoured; larger register values saturate to it
    localparam logic [DIM_W-1:0] MAX_SCREEN_DIM = 13'd4096;

    // Register reset values
    localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd1024;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd768;

    // Register indexes of the configuration port
    localparam logic CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic CFG_SCREEN_HEIGHT = 1'b1;

    // Character mapping
    localparam int          GLYPH_COUNT = 96;
    localparam logic [7:0]  FIRST_PRINT = 8'd32;
    localparam logic [7:0]  FIRST_HIGH  = 8'd128;
    localparam logic [6:0]  BLANK_INDEX = 7'd0;
    localparam logic [6:0]  QMARK_INDEX = 7'd31;

    typedef logic [7:0] t_row;

    // Font ROM: entry 0 is the space glyph, row 0 on top, bit x is column x
    localparam t_row GLYPH_ROM [GLYPH_COUNT][8] = '{
        '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
        '{8'h18,8'h3C,8'h3C,8'h18,8'h18,8'h00,8'h18,8'h00},
        '{8'h36,8'h36,8'h24,8'h00,8'h00,8'h00,8'h00,8'h00},
        '{8'h36,8'h36,8'h7F,8'h36,8'h7F,8'h36,8'h36,8'h00},
        '{8'h18,8'h3E,8'h03,8'h1E,8'h30,8'h1F,8'h18,8'h00},
        '{8'h00,8'h63,8'h33,8'h18,8'h0C,8'h66,8'h63,8'h00},
        '{8'h1C,8'h36,8'h1C,8'h6E,8'h3B,8'h33,8'h6E,8'h00},
        '{8'h06,8'h06,8'h03,8'h00,8'h00,8'h00,8'h00,8'h00},
        '{8'h18,8'h0C,8'h06,8'h06,8'h06,8'h0C,8'h18,8'h00},
        '{8'h06,8'h0C,8'h18,8'h18,8'h18,8'h0C,8'h06,8'h00},
        '{8'h00,8'h66,8'h3C,8'h7F,8'h3C,8'h66,8'h00,8'h00},
        '{8'h00,8'h0C,8'h0C,8'h3F,8'h0C,8'h0C,8'h00,8'h00},
        '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h0C,8'h0C,8'h06},
        '{8'h00,8'h00,8'h00,8'h3F,8'h00,8'h00,8'h00,8'h00},
        '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h0C,8'h0C,8'h00},
        '{8'h60,8'h30,8'h18,8'h0C,8'h06,8'h03,8'h01,8'h00},
        '{8'h3E,8'h63,8'h73,8'h7B,8'h6F,8'h67,8'h3E,8'h00},
        '{8'h0C,8'h0E,8'h0C,8'h0C,8'h0C,8'h0C,8'h3F,8'h00},
        '{8'h1E,8'h33,8'h30,8'h1C,8'h06,8'h33,8'h3F,8'h00},
        '{8'h1E,8'h33,8'h30,8'h1C,8'h30,8'h33,8'h1E,8'h00},
        '{8'h38,8'h3C,8'h36,8'h33,8'h7F,8'h30,8'h78,8'h00},
        '{8'h3F,8'h03,8'h1F,8'h30,8'h30,8'h33,8'h1E,8'h00},
        '{8'h1C,8'h06,8'h03,8'h1F,8'h33,8'h33,8'h1E,8'h00},
        '{8'h3F,8'h33,8'h30,8'h18,8'h0C,8'h0C,8'h0C,8'h00},
        '{8'h1E,8'h33,8'h33,8'h1E,8'h33,8'h33,8'h1E,8'h00},
        '{8'h1E,8'h33,8'h33,8'h3E,8'h30,8'h18,8'h0E,8'h00},
        '{8'h00,8'h0C,8'h0C,8'h00,8'h00,8'h0C,8'h0C,8'h00},
        '{8'h00,8'h0C,8'h0C,8'h00,8'h00,8'h0C,8'h0C,8'h06},
        '{8'h18,8'h0C,8'h06,8'h03,8'h06,8'h0C,8'h18,8'h00},
        '{8'h00,8'h00,8'h3F,8'h00,8'h00,8'h3F,8'h00,8'h00},
        '{8'h06,8'h0C,8'h18,8'h30,8'h18,8'h0C,8'h06,8'h00},
        '{8'h1E,8'h33,8'h30,8'h18,8'h0C,8'h00,8'h0C,8'h00},
        '{8'h3E,8'h63,8'h7B,8'h7B,8'h7B,8'h03,8'h1E,8'h00},
        '{8'h0C,8'h1E,8'h33,8'h33,8'h3F,8'h33,8'h33,8'h00},
        '{8'h3F,8'h66,8'h66,8'h3E,8'h66,8'h66,8'h3F,8'h00},
        '{8'h3C,8'h66,8'h03,8'h03,8'h03,8'h66,8'h3C,8'h00},
        '{8'h1F,8'h36,8'h66,8'h66,8'h66,8'h36,8'h1F,8'h00},
        '{8'h7F,8'h46,8'h16,8'h1E,8'h16,8'h46,8'h7F,8'h00},
        '{8'h7F,8'h46,8'h16,8'h1E,8'h16,8'h06,8'h0F,8'h00},
        '{8'h3C,8'h66,8'h03,8'h03,8'h73,8'h66,8'h7C,8'h00},
        '{8'h33,8'h33,8'h33,8'h3F,8'h33,8'h33,8'h33,8'h00},
        '{8'h1E,8'h0C,8'h0C,8'h0C,8'h0C,8'h0C,8'h1E,8'h00},
        '{8'h78,8'h30,8'h30,8'h30,8'h33,8'h33,8'h1E,8'h00},
        '{8'h67,8'h66,8'h36,8'h1E,8'h36,8'h66,8'h67,8'h00},
        '{8'h0F,8'h06,8'h06,8'h06,8'h46,8'h66,8'h7F,8'h00},
        '{8'h63,8'h77,8'h7F,8'h7F,8'h6B,8'h63,8'h63,8'h00},
        '{8'h63,8'h67,8'h6F,8'h7B,8'h73,8'h63,8'h63,8'h00},
        '{8'h1C,8'h36,8'h63,8'h63,8'h63,8'h36,8'h1C,8'h00},
        '{8'h3F,8'h66,8'h66,8'h3E,8'h06,8'h06,8'h0F,8'h00},
        '{8'h1E,8'h33,8'h33,8'h33,8'h3B,8'h1E,8'h38,8'h00},
        '{8'h3F,8'h66,8'h66,8'h3E,8'h36,8'h66,8'h67,8'h00},
        '{8'h1E,8'h33,8'h07,8'h0E,8'h38,8'h33,8'h1E,8'h00},
        '{8'h3F,8'h2D,8'h0C,8'h0C,8'h0C,8'h0C,8'h1E,8'h00},
        '{8'h33,8'h33,8'h33,8'h33,8'h33,8'h33,8'h3F,8'h00},
        '{8'h33,8'h33,8'h33,8'h33,8'h33,8'h1E,8'h0C,8'h00},
        '{8'h63,8'h63,8'h63,8'h6B,8'h7F,8'h77,8'h63,8'h00},
        '{8'h63,8'h63,8'h36,8'h1C,8'h1C,8'h36,8'h63,8'h00},
        '{8'h33,8'h33,8'h33,8'h1E,8'h0C,8'h0C,8'h1E,8'h00},
        '{8'h7F,8'h73,8'h19,8'h0C,8'h26,8'h63,8'h7F,8'h00},
        '{8'h1E,8'h06,8'h06,8'h06,8'h06,8'h06,8'h1E,8'h00},
        '{8'h03,8'h06,8'h0C,8'h18,8'h30,8'h60,8'h40,8'h00},
        '{8'h1E,8'h18,8'h18,8'h18,8'h18,8'h18,8'h1E,8'h00},
        '{8'h08,8'h1C,8'h36,8'h63,8'h00,8'h00,8'h00,8'h00},
        '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'hFF},
        '{8'h0C,8'h0C,8'h18,8'h00,8'h00,8'h00,8'h00,8'h00},
        '{8'h00,8'h00,8'h1E,8'h30,8'h3E,8'h33,8'h6E,8'h00},
        '{8'h07,8'h06,8'h06,8'h3E,8'h66,8'h66,8'h3B,8'h00},
        '{8'h00,8'h00,8'h1E,8'h33,8'h03,8'h33,8'h1E,8'h00},
        '{8'h38,8'h30,8'h30,8'h3E,8'h33,8'h33,8'h6E,8'h00},
        '{8'h00,8'h00,8'h1E,8'h33,8'h3F,8'h03,8'h1E,8'h00},
        '{8'h1C,8'h36,8'h06,8'h0F,8'h06,8'h06,8'h0F,8'h00},
        '{8'h00,8'h00,8'h6E,8'h33,8'h33,8'h3E,8'h30,8'h1F},
        '{8'h07,8'h06,8'h36,8'h6E,8'h66,8'h66,8'h67,8'h00},
        '{8'h0C,8'h00,8'h0E,8'h0C,8'h0C,8'h0C,8'h1E,8'h00},
        '{8'h30,8'h00,8'h30,8'h30,8'h30,8'h33,8'h33,8'h1E},
        '{8'h07,8'h06,8'h66,8'h36,8'h1E,8'h36,8'h67,8'h00},
        '{8'h0E,8'h0C,8'h0C,8'h0C,8'h0C,8'h0C,8'h1E,8'h00},
        '{8'h00,8'h00,8'h33,8'h7F,8'h7F,8'h6B,8'h63,8'h00},
        '{8'h00,8'h00,8'h1F,8'h33,8'h33,8'h33,8'h33,8'h00},
        '{8'h00,8'h00,8'h1E,8'h33,8'h33,8'h33,8'h1E,8'h00},
        '{8'h00,8'h00,8'h3B,8'h66,8'h66,8'h3E,8'h06,8'h0F},
        '{8'h00,8'h00,8'h6E,8'h33,8'h33,8'h3E,8'h30,8'h78},
        '{8'h00,8'h00,8'h3B,8'h6E,8'h66,8'h06,8'h0F,8'h00},
        '{8'h00,8'h00,8'h3E,8'h03,8'h1E,8'h30,8'h1F,8'h00},
        '{8'h08,8'h0C,8'h3E,8'h0C,8'h0C,8'h2C,8'h18,8'h00},
        '{8'h00,8'h00,8'h33,8'h33,8'h33,8'h33,8'h6E,8'h00},
        '{8'h00,8'h00,8'h33,8'h33,8'h33,8'h1E,8'h0C,8'h00},
        '{8'h00,8'h00,8'h63,8'h6B,8'h7F,8'h7F,8'h36,8'h00},
        '{8'h00,8'h00,8'h63,8'h36,8'h1C,8'h36,8'h63,8'h00},
        '{8'h00,8'h00,8'h33,8'h33,8'h33,8'h3E,8'h30,8'h1F},
        '{8'h00,8'h00,8'h3F,8'h19,8'h0C,8'h26,8'h3F,8'h00},
        '{8'h38,8'h0C,8'h0C,8'h07,8'h0C,8'h0C,8'h38,8'h00},
        '{8'h18,8'h18,8'h18,8'h00,8'h18,8'h18,8'h18,8'h00},
        '{8'h07,8'h0C,8'h0C,8'h38,8'h0C,8'h0C,8'h07,8'h00},
        '{8'h6E,8'h3B,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
        '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00}
    };

    // One prepared glyph request: font rows and the visible rectangle within the cell
    typedef struct packed {
        logic [7:0][7:0]      glyph;    // glyph[r][c]
        logic [COLOR_W-1:0]   fg;
        logic [COLOR_W-1:0]   bg;
        logic [2:0]           row_first;
        logic [2:0]           row_last;
        logic [2:0]           col_first;
        logic [2:0]           col_last;
        logic [SCR_W-1:0]     sy0;      // screen row of the first visible pixel
        logic [SCR_W-1:0]     sx0;      // screen column of the first visible pixel
    } t_job;

endpackage

### hw/rtl/gb8_prep.sv
`timescale 1ns / 1ps
// Input stage of the glyph blitter: glyph lookup and clipping into a registered job.
// Depends on gb8_pkg.
module gb8_prep (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [gb8_pkg::CODE_W-1:0]    i_char_code,
    input  logic [gb8_pkg::COORD_W-1:0]   i_pos_x,
    input  logic [gb8_pkg::COORD_W-1:0]   i_pos_y,
    input  logic [gb8_pkg::COLOR_W-1:0]   i_fg_color,
    input  logic [gb8_pkg::COLOR_W-1:0]   i_bg_color,
    input  logic [gb8_pkg::DIM_W-1:0]     i_width,
    input  logic [gb8_pkg::DIM_W-1:0]     i_height,
    input  logic                          i_take,
    output logic                          o_job_valid,
    output gb8_pkg::t_job                 o_job
);

    logic          r_valid;
    gb8_pkg::t_job r_job;
    gb8_pkg::t_job n_job;
    logic          accept;
    logic [6:0]    glyph_idx;
    logic [7:0]    row_vis;
    logic [7:0]    col_vis;
    logic          empty;

    // A request is taken when the job register is free or drains this cycle
    assign o_in_stall = r_valid && !i_take;
    assign accept     = i_in_valid && !o_in_stall;

    // Character code to font entry
    always_comb begin
        priority if (i_char_code < gb8_pkg::FIRST_PRINT) begin
            glyph_idx = gb8_pkg::BLANK_INDEX;
        end else if (i_char_code >= gb8_pkg::FIRST_HIGH) begin
            glyph_idx = gb8_pkg::QMARK_INDEX;
        end else begin
            glyph_idx = 7'(i_char_code - gb8_pkg::FIRST_PRINT);
        end
    end

    // Which rows and columns of the cell land on the screen
    always_comb begin
        logic [13:0] sy;
        logic [13:0] sx;
        for (int i = 0; i < 8; i++) begin
            sy = {i_pos_y[12], i_pos_y} + 14'(i);
            sx = {i_pos_x[12], i_pos_x} + 14'(i);
            row_vis[i] = !sy[13] && (sy < {1'b0, i_height});
            col_vis[i] = !sx[13] && (sx < {1'b0, i_width});
        end
    end

    assign empty = (row_vis == 8'd0) || (col_vis == 8'd0);

    // Build the job: bounds of the visible rectangle and its first screen pixel
    always_comb begin
        n_job     = '0;
        for (int r = 0; r < 8; r++) begin
            n_job.glyph[r] = gb8_pkg::GLYPH_ROM[glyph_idx][r];
        end
        n_job.fg  = i_fg_color;
        n_job.bg  = i_bg_color;
        for (int i = 0; i < 8; i++) begin
            if (row_vis[i]) begin
                n_job.row_last = 3'(i);
            end
            if (col_vis[i]) begin
                n_job.col_last = 3'(i);
            end
        end
        for (int i = 7; i >= 0; i--) begin
            if (row_vis[i]) begin
                n_job.row_first = 3'(i);
            end
            if (col_vis[i]) begin
                n_job.col_first = 3'(i);
            end
        end
        n_job.sy0 = i_pos_y[12] ? '0 : i_pos_y[gb8_pkg::SCR_W-1:0];
        n_job.sx0 = i_pos_x[12] ? '0 : i_pos_x[gb8_pkg::SCR_W-1:0];
    end

    // Fully clipped glyphs are swallowed here and never reach the scanner
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= !empty;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job <= n_job;
        end
    end

    assign o_job_valid = r_valid;
    assign o_job       = r_job;

endmodule

### hw/rtl/gb8_scan.sv
`timescale 1ns / 1ps
// Pixel scanner of the glyph blitter: walks the visible rectangle one pixel per
// cycle unless stalled; drives the registered result port. Depends on gb8_pkg.
module gb8_scan (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_job_valid,
    input  gb8_pkg::t_job                 i_job,
    output logic                          o_take,
    input  logic [gb8_pkg::DIM_W-1:0]     i_width,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [gb8_pkg::ADDR_W-1:0]    o_pixel_addr,
    output logic [gb8_pkg::COLOR_W-1:0]   o_pixel_value,
    output logic                          o_last_pixel
);

    logic                          r_busy;
    gb8_pkg::t_job                 r_job;
    logic [2:0]                    r_row;
    logic [2:0]                    r_col;
    logic [gb8_pkg::ADDR_W-1:0]    r_addr;
    logic [gb8_pkg::DIM_W-1:0]     r_stride;
    logic                          r_out_valid;
    logic [gb8_pkg::ADDR_W-1:0]    r_out_addr;
    logic [gb8_pkg::COLOR_W-1:0]   r_out_value;
    logic                          r_out_last;

    logic                          out_free;
    logic                          emit;
    logic                          cur_last;
    logic                          row_end;
    logic                          load;
    logic                          pix_bit;
    logic [24:0]                   base_prod;
    logic [gb8_pkg::ADDR_W-1:0]    n_base;
    logic [gb8_pkg::DIM_W-1:0]     n_stride;

    // Handshake between scanner, job register and result register
    assign out_free = !r_out_valid || !i_out_stall;
    assign emit     = r_busy && out_free;
    assign row_end  = (r_col == r_job.col_last);
    assign cur_last = (r_row == r_job.row_last) && row_end;
    assign load     = i_job_valid && (!r_busy || (emit && cur_last));
    assign o_take   = load;

    // Address of the first visible pixel, and the step from a row's end to the next row
    assign base_prod = {13'd0, i_job.sy0} * {12'd0, i_width};
    assign n_base    = gb8_pkg::ADDR_W'(base_prod + {13'd0, i_job.sx0});
    assign n_stride  = i_width - {10'd0, 3'(i_job.col_last - i_job.col_first)};

    assign pix_bit = r_job.glyph[r_row][r_col];

    // Scanner control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (load) begin
            r_busy <= 1'b1;
        end else if (emit && cur_last) begin
            r_busy <= 1'b0;
        end
    end

    // Scan position and running address
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job    <= i_job;
            r_row    <= i_job.row_first;
            r_col    <= i_job.col_first;
            r_addr   <= n_base;
            r_stride <= n_stride;
        end else if (emit && !cur_last) begin
            if (row_end) begin
                r_row  <= r_row + 3'd1;
                r_col  <= r_job.col_first;
                r_addr <= r_addr + {11'd0, r_stride};
            end else begin
                r_col  <= r_col + 3'd1;
                r_addr <= r_addr + 24'd1;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_addr  <= r_addr;
            r_out_value <= pix_bit ? r_job.fg : r_job.bg;
            r_out_last  <= cur_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_addr  = r_out_addr;
    assign o_pixel_value = r_out_value;
    assign o_last_pixel  = r_out_last;

endmodule

### hw/rtl/glyph_blitter_8x8_top.sv
`timescale 1ns / 1ps
// Top level of the 8x8 glyph blitter: configuration registers, input stage and scanner.
// Depends on gb8_pkg, gb8_prep and gb8_scan.
//
// Usage
//   Each request on the input channel (i_in_valid / o_in_stall) draws one glyph at a
//   signed screen position. The output channel (o_out_valid / i_out_stall) delivers one
//   pixel per request: its linear address row * width + column and its colour, in
//   row-major order, with o_last_pixel set on the final visible pixel of the glyph.
//   A glyph lying wholly off screen is consumed and yields no pixel requests.
//   The first pixel of a glyph passes the job register of the input stage, the
//   scanner registers and the result register. One pixel per cycle is delivered while
//   the output is not stalled; a glyph fully on screen has 64 visible pixels. A new
//   glyph is accepted while the previous one is still being scanned, and its pixels
//   follow the previous glyph's last pixel without a gap.
//   A stall on the output holds the result register and, behind it, the scanner and
//   the input stage; nothing is lost or repeated.
//   Reset (synchronous, active low) empties all stages and sets the screen to
//   1024 x 768. The user must write screen width and height through the configuration
//   port only while the block is idle (not enforced); values above 4096 act as 4096.
module glyph_blitter_8x8_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [gb8_pkg::DIM_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [gb8_pkg::CODE_W-1:0]    i_char_code,
    input  logic [gb8_pkg::COORD_W-1:0]   i_pos_x,
    input  logic [gb8_pkg::COORD_W-1:0]   i_pos_y,
    input  logic [gb8_pkg::COLOR_W-1:0]   i_fg_color,
    input  logic [gb8_pkg::COLOR_W-1:0]   i_bg_color,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [gb8_pkg::ADDR_W-1:0]    o_pixel_addr,
    output logic [gb8_pkg::COLOR_W-1:0]   o_pixel_value,
    output logic                          o_last_pixel
);

    logic [gb8_pkg::DIM_W-1:0] r_screen_width;
    logic [gb8_pkg::DIM_W-1:0] r_screen_height;
    logic [gb8_pkg::DIM_W-1:0] width_eff;
    logic [gb8_pkg::DIM_W-1:0] height_eff;
    logic                      job_valid;
    logic                      job_take;
    gb8_pkg::t_job             job;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width  <= gb8_pkg::WIDTH_RESET;
            r_screen_height <= gb8_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                gb8_pkg::CFG_SCREEN_WIDTH:  r_screen_width  <= i_cfg_data;
                gb8_pkg::CFG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data;
            endcase
        end
    end

    // Oversized dimensions saturate to the largest supported screen
    assign width_eff  = (r_screen_width > gb8_pkg::MAX_SCREEN_DIM) ?
                        gb8_pkg::MAX_SCREEN_DIM : r_screen_width;
    assign height_eff = (r_screen_height > gb8_pkg::MAX_SCREEN_DIM) ?
                        gb8_pkg::MAX_SCREEN_DIM : r_screen_height;

    gb8_prep u_prep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_char_code (i_char_code),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_fg_color  (i_fg_color),
        .i_bg_color  (i_bg_color),
        .i_width     (width_eff),
        .i_height    (height_eff),
        .i_take      (job_take),
        .o_job_valid (job_valid),
        .o_job       (job)
    );

    gb8_scan u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (job_valid),
        .i_job         (job),
        .o_take        (job_take),
        .i_width       (width_eff),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pixel_addr  (o_pixel_addr),
        .o_pixel_value (o_pixel_value),
        .o_last_pixel  (o_last_pixel)
    );

endmodule
